>>> rtl/core/stp_pkg.sv
// self-tuning pid: shared constants, register indexes, saturation and magnitude helpers
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps

package stp_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC   = 16;
    localparam int ERR_W  = 32;
    localparam int INT_W  = 48;
    localparam int ABS_W  = 48;
    localparam int SQ_W   = 64;
    localparam int CNT_W  = 16;
    localparam int RATE_W = 32;
    localparam int THR_W  = 31;
    localparam int RMS_W  = 32;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 32;

    localparam int RMS_DIV = 100;
    // divisor for the mean of squares is at most 2^CNT_W
    localparam int DIV_W   = CNT_W + 1;

    // 100 * 2^16 = 25 * 2^18: shift by 18, then divide by 25 with a reciprocal
    localparam int          LR_PRE_SH   = FRAC + 2;
    localparam int          LR_RECIP_SH = 51;
    localparam logic [63:0] LR_RECIP    = 64'd90071992547410;

    localparam logic [127:0] TERM_LIMIT = 128'(1) << 60;

    localparam logic signed [DATA_W-1:0] KP_RST  = DATA_W'(65536);
    localparam logic [RATE_W-1:0]        LR_RST  = RATE_W'(42950);
    localparam logic [CNT_W-1:0]         LEN_RST = CNT_W'(100);
    localparam logic [THR_W-1:0]         THR_RST = THR_W'(65536);

    typedef enum logic [IDX_W-1:0] {
        REG_KP  = 3'd0,
        REG_KI  = 3'd1,
        REG_KD  = 3'd2,
        REG_LR  = 3'd3,
        REG_LEN = 3'd4,
        REG_THR = 3'd5
    } reg_idx_t;

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [63:0] x);
        logic signed [63:0] hi_lim;
        logic signed [63:0] lo_lim;
        hi_lim = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
        lo_lim = -(64'sd1 <<< (DATA_W - 1));
        if (x > hi_lim)
            return DATA_W'(hi_lim);
        else if (x < lo_lim)
            return DATA_W'(lo_lim);
        else
            return DATA_W'(x);
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

endpackage

>>> rtl/core/stp_if.sv
// self-tuning pid: valid/ready channel interfaces for samples, drive and configuration
// depends on stp_pkg
`timescale 1ns / 1ps

interface stp_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [stp_pkg::ERR_W-1:0]    error_sample;
    modport source (output valid, output error_sample, input ready);
    modport sink (input valid, input error_sample, output ready);
endinterface

interface stp_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [stp_pkg::DATA_W-1:0]   steer;
    logic                                tuning_active;
    logic                                epoch_end;
    modport source (output valid, output steer, output tuning_active, output epoch_end,
                    input ready);
    modport sink (input valid, input steer, input tuning_active, input epoch_end,
                  output ready);
endinterface

interface stp_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [stp_pkg::IDX_W-1:0]           index;
    logic [stp_pkg::CFG_W-1:0]           data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/self_tuning_pid.sv
// self-tuning pid controller with gradient-descent gain adaptation
// depends on stp_pkg and the channel interfaces in stp_if.sv
`timescale 1ns / 1ps

// Usage
//   samples : one signed Q16.16 control error per transfer
//   drive   : one result per sample: saturated steer, tuning flag, epoch-end flag
//   cfg     : register writes (gains, learning rate, epoch length, rms threshold),
//             always ready; a gain or learning-rate write also loads the working value.
//             Write only while no sample is in flight.
// Throughput
//   one sample at a time; an ordinary sample goes through the square and the three gain
//   products. A sample that closes an epoch while tuning adds the division, the square
//   root, the learning-rate update and the three gain updates; the gain updates are
//   skipped when tuning stops on that epoch. The work is done by one shared 32x32 multiplier
//   (four partial products per product, up to 15 products), a bit-serial 64-bit divider
//   for the mean of squares and a bit-serial square root.
// Reset
//   gains, learning rate and registers return to their defaults, sums and
//   epoch count clear, tuning is active; no result pending.
// Stall
//   the result waits in an output register; the next sample is taken while it
//   waits, and its own result is held back until the register frees.

module self_tuning_pid (
    input  logic         clk,
    input  logic         rst_n,
    stp_in_if.sink       samples,
    stp_out_if.source    drive,
    stp_cfg_if.sink      cfg
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_MUL, ST_FIN, ST_DIV, ST_SQRT, ST_RMS, ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        STEP_SQ, STEP_KP, STEP_KD, STEP_KI, STEP_RMS, STEP_LR, STEP_LRQ,
        STEP_G0A, STEP_G0B, STEP_G0C,
        STEP_G1A, STEP_G1B, STEP_G1C,
        STEP_G2A, STEP_G2B, STEP_G2C
    } step_t;

    state_t state_reg;
    step_t  step_reg;

    logic signed [stp_pkg::DATA_W-1:0] gain_reg [3];
    logic [stp_pkg::RATE_W-1:0]        lr_reg;
    logic [stp_pkg::CNT_W-1:0]         len_reg;
    logic [stp_pkg::THR_W-1:0]         thr_reg;

    logic signed [stp_pkg::ERR_W-1:0]  last_err_reg;
    logic signed [stp_pkg::INT_W-1:0]  integ_reg;
    logic [stp_pkg::ABS_W-1:0]         abs_sum_reg;
    logic [stp_pkg::SQ_W-1:0]          sq_sum_reg;
    logic [stp_pkg::CNT_W-1:0]         cnt_reg;
    logic                              tune_reg;
    logic [stp_pkg::RMS_W-1:0]         prev_rms_reg;

    logic signed [stp_pkg::ERR_W-1:0]  e_reg;
    logic signed [stp_pkg::ERR_W:0]    derr_reg;
    logic                              closed_reg;
    logic [stp_pkg::RMS_W-1:0]         rms_reg;
    logic signed [stp_pkg::RMS_W:0]    delta_reg;
    logic signed [63:0]                t_reg;
    logic signed [63:0]                steer_sum_reg;
    logic signed [stp_pkg::DATA_W-1:0] steer_res_reg;

    logic [63:0]                       mul_a_reg;
    logic [63:0]                       mul_b_reg;
    logic                              mul_neg_reg;
    logic [127:0]                      acc_reg;
    logic [1:0]                        mul_cnt_reg;

    logic [63:0]                       div_num_reg;
    logic [stp_pkg::DIV_W-1:0]         div_rem_reg;
    logic [stp_pkg::DIV_W-1:0]         div_den_reg;
    logic [5:0]                        iter_reg;

    logic [63:0]                       sq_v_reg;
    logic [63:0]                       sq_r_reg;
    logic [63:0]                       sq_bit_reg;

    logic                              out_valid_reg;
    logic signed [stp_pkg::DATA_W-1:0] out_steer_reg;
    logic                              out_tune_reg;
    logic                              out_end_reg;

    // operand selection for the shared multiplier
    logic signed [63:0] op_a;
    logic signed [63:0] op_b;

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (step_reg)
            STEP_SQ:
            begin
                op_a = 64'(e_reg);
                op_b = 64'(e_reg);
            end
            STEP_KP:
            begin
                op_a = 64'(gain_reg[0]);
                op_b = 64'(e_reg);
            end
            STEP_KD:
            begin
                op_a = 64'(gain_reg[2]);
                op_b = 64'(derr_reg);
            end
            STEP_KI:
            begin
                op_a = 64'(gain_reg[1]);
                op_b = 64'(integ_reg);
            end
            STEP_LR:
            begin
                op_a = signed'(64'(lr_reg));
                op_b = signed'(64'(rms_reg));
            end
            STEP_LRQ:
            begin
                op_a = signed'(64'(acc_reg[63:stp_pkg::LR_PRE_SH]));
                op_b = signed'(stp_pkg::LR_RECIP);
            end
            STEP_G0A:
            begin
                op_a = 64'(gain_reg[0]);
                op_b = 64'(e_reg);
            end
            STEP_G1A:
            begin
                op_a = 64'(gain_reg[1]);
                op_b = signed'(64'(abs_sum_reg));
            end
            STEP_G2A:
            begin
                op_a = 64'(gain_reg[2]);
                op_b = 64'(derr_reg);
            end
            STEP_G0B, STEP_G1B, STEP_G2B:
            begin
                op_a = t_reg;
                op_b = 64'(delta_reg);
            end
            STEP_G0C, STEP_G1C, STEP_G2C:
            begin
                op_a = t_reg;
                op_b = signed'(64'(lr_reg));
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // one 32x32 partial product per cycle
    logic [31:0]  pp_a;
    logic [31:0]  pp_b;
    logic [63:0]  pp;
    logic [127:0] addend;

    always_comb
    begin
        pp_a = mul_cnt_reg[1] ? mul_a_reg[63:32] : mul_a_reg[31:0];
        pp_b = mul_cnt_reg[0] ? mul_b_reg[63:32] : mul_b_reg[31:0];
        pp   = pp_a * pp_b;
        case (mul_cnt_reg)
            2'd0:    addend = {64'd0, pp};
            2'd3:    addend = {pp, 64'd0};
            default: addend = {32'd0, pp, 32'd0};
        endcase
    end

    // shift, clamp to 2^60 and restore sign
    logic               sh32;
    logic [127:0]       shifted;
    logic [63:0]        clamped;
    logic signed [63:0] term;
    logic signed [63:0] steer_total;
    logic signed [63:0] gain_diff;
    logic [64:0]        sq_add;

    always_comb
    begin
        sh32        = (step_reg == STEP_G0C) || (step_reg == STEP_G1C) || (step_reg == STEP_G2C);
        shifted     = sh32 ? (acc_reg >> 32) : (acc_reg >> stp_pkg::FRAC);
        clamped     = (shifted > stp_pkg::TERM_LIMIT) ? stp_pkg::TERM_LIMIT[63:0]
                                                      : shifted[63:0];
        term        = mul_neg_reg ? -signed'(clamped) : signed'(clamped);
        steer_total = steer_sum_reg + term;
        gain_diff   = 64'(gain_reg[0]) - term;
        unique case (step_reg)
            STEP_G1C: gain_diff = 64'(gain_reg[1]) - term;
            STEP_G2C: gain_diff = 64'(gain_reg[2]) - term;
            default:  gain_diff = 64'(gain_reg[0]) - term;
        endcase
        sq_add = {1'b0, sq_sum_reg} + {1'b0, acc_reg[63:0]};
    end

    // bit-serial divider step
    logic [stp_pkg::DIV_W:0]   div_trial;
    logic                      div_take;
    logic [stp_pkg::DIV_W-1:0] div_rem_next;
    logic [63:0]               div_num_next;

    always_comb
    begin
        div_trial    = {div_rem_reg, div_num_reg[63]};
        div_take     = div_trial >= {1'b0, div_den_reg};
        div_rem_next = div_take ? stp_pkg::DIV_W'(div_trial - {1'b0, div_den_reg})
                                : div_trial[stp_pkg::DIV_W-1:0];
        div_num_next = {div_num_reg[62:0], div_take};
    end

    // square root step, one result bit per pair of radicand bits
    logic [63:0] sq_trial;
    logic        sq_take;

    always_comb
    begin
        sq_trial = sq_r_reg + sq_bit_reg;
        sq_take  = sq_v_reg >= sq_trial;
    end

    // sample-side arithmetic at transfer
    logic signed [stp_pkg::INT_W:0]    integ_sum;
    logic signed [stp_pkg::INT_W-1:0]  integ_next;
    logic [stp_pkg::ERR_W-1:0]         abs_e;
    logic [stp_pkg::ABS_W:0]           abs_add;
    logic [stp_pkg::ABS_W-1:0]         abs_next;
    logic [stp_pkg::CNT_W-1:0]         cnt_inc;

    always_comb
    begin
        integ_sum = (stp_pkg::INT_W + 1)'(integ_reg) + (stp_pkg::INT_W + 1)'(samples.error_sample);
        if (integ_sum[stp_pkg::INT_W] != integ_sum[stp_pkg::INT_W-1])
            integ_next = integ_sum[stp_pkg::INT_W] ? {1'b1, {(stp_pkg::INT_W-1){1'b0}}}
                                                   : {1'b0, {(stp_pkg::INT_W-1){1'b1}}};
        else
            integ_next = integ_sum[stp_pkg::INT_W-1:0];
        abs_e    = samples.error_sample[stp_pkg::ERR_W-1]
                   ? stp_pkg::ERR_W'(-samples.error_sample)
                   : stp_pkg::ERR_W'(samples.error_sample);
        abs_add  = {1'b0, abs_sum_reg} + (stp_pkg::ABS_W + 1)'(abs_e);
        abs_next = abs_add[stp_pkg::ABS_W] ? '1 : abs_add[stp_pkg::ABS_W-1:0];
        cnt_inc  = cnt_reg + 1'b1;
    end

    assign samples.ready       = (state_reg == ST_IDLE);
    assign cfg.ready           = 1'b1;
    assign drive.valid         = out_valid_reg;
    assign drive.steer         = out_steer_reg;
    assign drive.tuning_active = out_tune_reg;
    assign drive.epoch_end     = out_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_SQ;
            gain_reg[0]   <= stp_pkg::KP_RST;
            gain_reg[1]   <= '0;
            gain_reg[2]   <= '0;
            lr_reg        <= stp_pkg::LR_RST;
            len_reg       <= stp_pkg::LEN_RST;
            thr_reg       <= stp_pkg::THR_RST;
            last_err_reg  <= '0;
            integ_reg     <= '0;
            abs_sum_reg   <= '0;
            sq_sum_reg    <= '0;
            cnt_reg       <= '0;
            tune_reg      <= 1'b1;
            prev_rms_reg  <= '0;
            e_reg         <= '0;
            derr_reg      <= '0;
            closed_reg    <= 1'b0;
            rms_reg       <= '0;
            delta_reg     <= '0;
            t_reg         <= '0;
            steer_sum_reg <= '0;
            steer_res_reg <= '0;
            mul_a_reg     <= '0;
            mul_b_reg     <= '0;
            mul_neg_reg   <= 1'b0;
            acc_reg       <= '0;
            mul_cnt_reg   <= '0;
            div_num_reg   <= '0;
            div_rem_reg   <= '0;
            div_den_reg   <= '0;
            iter_reg      <= '0;
            sq_v_reg      <= '0;
            sq_r_reg      <= '0;
            sq_bit_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_steer_reg <= '0;
            out_tune_reg  <= 1'b0;
            out_end_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    stp_pkg::REG_KP:  gain_reg[0] <= stp_pkg::DATA_W'(signed'(cfg.data));
                    stp_pkg::REG_KI:  gain_reg[1] <= stp_pkg::DATA_W'(signed'(cfg.data));
                    stp_pkg::REG_KD:  gain_reg[2] <= stp_pkg::DATA_W'(signed'(cfg.data));
                    stp_pkg::REG_LR:  lr_reg      <= cfg.data[stp_pkg::RATE_W-1:0];
                    stp_pkg::REG_LEN: len_reg     <= cfg.data[stp_pkg::CNT_W-1:0];
                    stp_pkg::REG_THR: thr_reg     <= cfg.data[stp_pkg::THR_W-1:0];
                    default: ;
                endcase
            end

            // in ST_OUT the output register is loaded below instead
            if (out_valid_reg && drive.ready && (state_reg != ST_OUT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (samples.valid)
                    begin
                        e_reg        <= samples.error_sample;
                        derr_reg     <= (stp_pkg::ERR_W + 1)'(samples.error_sample)
                                        - (stp_pkg::ERR_W + 1)'(last_err_reg);
                        last_err_reg <= samples.error_sample;
                        integ_reg    <= integ_next;
                        abs_sum_reg  <= abs_next;
                        step_reg     <= STEP_SQ;
                        state_reg    <= ST_LOAD;
                    end
                end

                ST_LOAD:
                begin
                    mul_a_reg   <= stp_pkg::mag64(op_a);
                    mul_b_reg   <= stp_pkg::mag64(op_b);
                    mul_neg_reg <= op_a[63] ^ op_b[63];
                    acc_reg     <= '0;
                    mul_cnt_reg <= '0;
                    state_reg   <= ST_MUL;
                end

                ST_MUL:
                begin
                    acc_reg     <= acc_reg + addend;
                    mul_cnt_reg <= mul_cnt_reg + 1'b1;
                    if (mul_cnt_reg == 2'd3)
                        state_reg <= ST_FIN;
                end

                ST_FIN:
                begin
                    unique case (step_reg)
                        STEP_SQ:
                        begin
                            sq_sum_reg <= sq_add[64] ? '1 : sq_add[63:0];
                            step_reg   <= STEP_KP;
                            state_reg  <= ST_LOAD;
                        end
                        STEP_KP:
                        begin
                            steer_sum_reg <= term;
                            step_reg      <= STEP_KD;
                            state_reg     <= ST_LOAD;
                        end
                        STEP_KD:
                        begin
                            steer_sum_reg <= steer_total;
                            step_reg      <= STEP_KI;
                            state_reg     <= ST_LOAD;
                        end
                        STEP_KI:
                        begin
                            steer_res_reg <= stp_pkg::sat_data(steer_total);
                            if (cnt_inc == len_reg)
                            begin
                                closed_reg <= 1'b1;
                                cnt_reg    <= '0;
                                if (tune_reg)
                                begin
                                    // zero length means an epoch of 65536 samples
                                    div_num_reg <= sq_sum_reg;
                                    div_den_reg <= (len_reg == '0)
                                                   ? stp_pkg::DIV_W'(1 << stp_pkg::CNT_W)
                                                   : stp_pkg::DIV_W'(len_reg);
                                    div_rem_reg <= '0;
                                    iter_reg    <= '0;
                                    step_reg    <= STEP_RMS;
                                    state_reg   <= ST_DIV;
                                end
                                else
                                    state_reg <= ST_OUT;
                            end
                            else
                            begin
                                closed_reg <= 1'b0;
                                cnt_reg    <= cnt_inc;
                                state_reg  <= ST_OUT;
                            end
                        end
                        STEP_LR:
                        begin
                            step_reg  <= STEP_LRQ;
                            state_reg <= ST_LOAD;
                        end
                        STEP_LRQ:
                        begin
                            lr_reg <= (acc_reg[127:stp_pkg::LR_RECIP_SH + stp_pkg::RATE_W] != '0)
                                      ? '1 : acc_reg[stp_pkg::LR_RECIP_SH +: stp_pkg::RATE_W];
                            if (tune_reg)
                            begin
                                step_reg  <= STEP_G0A;
                                state_reg <= ST_LOAD;
                            end
                            else
                            begin
                                abs_sum_reg <= '0;
                                sq_sum_reg  <= '0;
                                state_reg   <= ST_OUT;
                            end
                        end
                        STEP_G0A, STEP_G1A, STEP_G2A:
                        begin
                            t_reg     <= term;
                            step_reg  <= step_t'(step_reg + 1'b1);
                            state_reg <= ST_LOAD;
                        end
                        STEP_G0B, STEP_G1B, STEP_G2B:
                        begin
                            t_reg     <= term;
                            step_reg  <= step_t'(step_reg + 1'b1);
                            state_reg <= ST_LOAD;
                        end
                        STEP_G0C:
                        begin
                            gain_reg[0] <= stp_pkg::sat_data(gain_diff);
                            step_reg    <= STEP_G1A;
                            state_reg   <= ST_LOAD;
                        end
                        STEP_G1C:
                        begin
                            gain_reg[1] <= stp_pkg::sat_data(gain_diff);
                            step_reg    <= STEP_G2A;
                            state_reg   <= ST_LOAD;
                        end
                        STEP_G2C:
                        begin
                            gain_reg[2] <= stp_pkg::sat_data(gain_diff);
                            abs_sum_reg <= '0;
                            sq_sum_reg  <= '0;
                            state_reg   <= ST_OUT;
                        end
                        default:
                            state_reg <= ST_OUT;
                    endcase
                end

                ST_DIV:
                begin
                    div_rem_reg <= div_rem_next;
                    div_num_reg <= div_num_next;
                    // the counter wraps to zero for the square root
                    iter_reg    <= iter_reg + 1'b1;
                    if (iter_reg == 6'd63)
                    begin
                        sq_v_reg   <= div_num_next;
                        sq_r_reg   <= '0;
                        sq_bit_reg <= 64'd1 << 62;
                        state_reg  <= ST_SQRT;
                    end
                end

                ST_SQRT:
                begin
                    if (sq_take)
                    begin
                        sq_v_reg <= sq_v_reg - sq_trial;
                        sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                    end
                    else
                        sq_r_reg <= sq_r_reg >> 1;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    iter_reg   <= iter_reg + 1'b1;
                    if (iter_reg == 6'd31)
                        state_reg <= ST_RMS;
                end

                ST_RMS:
                begin
                    rms_reg   <= sq_r_reg[stp_pkg::RMS_W-1:0];
                    delta_reg <= (stp_pkg::RMS_W + 1)'(prev_rms_reg)
                                 - (stp_pkg::RMS_W + 1)'(sq_r_reg[stp_pkg::RMS_W-1:0]);
                    if (sq_r_reg[stp_pkg::RMS_W-1:0] > stp_pkg::RMS_W'(thr_reg))
                    begin
                        tune_reg     <= 1'b1;
                        prev_rms_reg <= sq_r_reg[stp_pkg::RMS_W-1:0];
                    end
                    else
                        tune_reg <= 1'b0;
                    step_reg  <= STEP_LR;
                    state_reg <= ST_LOAD;
                end

                ST_OUT:
                begin
                    if (!out_valid_reg || drive.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_steer_reg <= steer_res_reg;
                        out_tune_reg  <= tune_reg;
                        out_end_reg   <= closed_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> bench/self_tuning_pid_tb.sv
// testbench for the self-tuning pid: drives error samples and register writes,
// predicts every drive result and checks it field by field
// depends on stp_pkg, stp_if.sv and self_tuning_pid
`timescale 1ns / 1ps

module self_tuning_pid_tb;

    localparam int DOG_LIMIT = 5000;
    localparam int SETTLE = 300;
    localparam logic [127:0] PROD_CLAMP = 128'(1) << 60;

    typedef struct packed {
        logic signed [stp_pkg::DATA_W-1:0] steer;
        logic                              tuning_active;
        logic                              epoch_end;
    } drive_t;

    logic clk;
    logic rst_n;

    stp_in_if  in_if ();
    stp_out_if out_if ();
    stp_cfg_if cfg_if ();

    self_tuning_pid dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (in_if.sink),
        .drive   (out_if.source),
        .cfg     (cfg_if.sink)
    );

    // pid state as the block should hold it
    longint      gain_p, gain_i, gain_d;
    logic [63:0] lrate;
    logic [15:0] ep_len;
    logic [63:0] rms_thr;
    longint      prev_err, err_sum;
    logic [63:0] abs_sum, sq_sum, prev_rms;
    logic [15:0] ep_cnt;
    logic        tuning;

    drive_t drive_q[$];
    int     mismatches;
    int     stall_left;
    bit     tx_quiet, rx_quiet;
    int     idle_cycles;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint clamp_signed(longint x, int bits);
        longint lim;
        lim = longint'(1) <<< (bits - 1);
        if (x > lim - 1)
            return lim - 1;
        if (x < -lim)
            return -lim;
        return x;
    endfunction

    // exact product, truncated toward zero and clamped to 2^60
    function automatic longint fx_mul(longint a, longint b, int sh);
        logic [63:0]  ma, mb;
        logic [127:0] p;
        longint       r;
        ma = a < 0 ? 64'(-a) : 64'(a);
        mb = b < 0 ? 64'(-b) : 64'(b);
        p = {64'd0, ma} * {64'd0, mb};
        p = p >> sh;
        if (p > PROD_CLAMP)
            p = PROD_CLAMP;
        r = longint'(p[63:0]);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint descend(longint g, longint x, longint delta);
        longint t;
        t = fx_mul(g, x, stp_pkg::FRAC);
        t = fx_mul(t, delta, stp_pkg::FRAC);
        t = fx_mul(t, longint'(lrate), 32);
        return clamp_signed(g - t, stp_pkg::DATA_W);
    endfunction

    function automatic drive_t predict_drive(logic signed [31:0] sample);
        drive_t      d;
        longint      e, derr, steer, delta;
        logic [63:0] ae, sq, rms, lr, len;
        logic [64:0] wide;
        e = longint'(sample);
        derr = e - prev_err;
        ae = e < 0 ? 64'(-e) : 64'(e);
        sq = ae * ae;
        prev_err = e;
        err_sum = clamp_signed(err_sum + e, stp_pkg::INT_W);
        abs_sum = abs_sum + ae;
        if (abs_sum > 64'hFFFF_FFFF_FFFF)
            abs_sum = 64'hFFFF_FFFF_FFFF;
        wide = {1'b0, sq_sum} + {1'b0, sq};
        sq_sum = wide[64] ? '1 : wide[63:0];
        // old gains drive this sample
        steer = fx_mul(gain_p, e, stp_pkg::FRAC) + fx_mul(gain_d, derr, stp_pkg::FRAC)
              + fx_mul(gain_i, err_sum, stp_pkg::FRAC);
        d.steer = stp_pkg::DATA_W'(clamp_signed(steer, stp_pkg::DATA_W));
        d.epoch_end = 1'b0;
        ep_cnt = ep_cnt + 16'd1;
        if (ep_cnt == ep_len)
        begin
            d.epoch_end = 1'b1;
            ep_cnt = 0;
            if (tuning)
            begin
                len = ep_len == 0 ? 64'd65536 : 64'(ep_len);
                rms = floor_sqrt(sq_sum / len);
                tuning = rms > rms_thr;
                lr = (lrate * rms) / (64'(stp_pkg::RMS_DIV) << stp_pkg::FRAC);
                lrate = lr > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : lr;
                if (tuning)
                begin
                    delta = longint'(prev_rms) - longint'(rms);
                    prev_rms = rms;
                    gain_p = descend(gain_p, e, delta);
                    gain_i = descend(gain_i, longint'(abs_sum), delta);
                    gain_d = descend(gain_d, derr, delta);
                end
                abs_sum = 0;
                sq_sum = 0;
            end
        end
        d.tuning_active = tuning;
        return d;
    endfunction

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic logic [31:0] rand_error();
        logic [31:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
            2: v = $urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000;
            3: v = 32'd1 << $urandom_range(0, 31);
            default: v = $urandom_range(0, 32'hFFF_FFFF) - 32'h800_0000;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_gain();
        if ($urandom_range(0, 5) == 0)
            return $urandom;
        return $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
    endfunction

    // result side: stall, then check each transfer against the oldest prediction
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            out_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        drive_t want;
        if (out_if.valid && out_if.ready)
        begin
            stall_left = draw_gap(rx_quiet);
            if (drive_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected drive: steer %h tuning %b epoch %b",
                             out_if.steer, out_if.tuning_active, out_if.epoch_end);
            end
            else
            begin
                want = drive_q.pop_front();
                if (out_if.steer !== want.steer || out_if.tuning_active !== want.tuning_active
                    || out_if.epoch_end !== want.epoch_end)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("drive mismatch: steer %h/%h tuning %b/%b epoch %b/%b",
                                 want.steer, out_if.steer, want.tuning_active,
                                 out_if.tuning_active, want.epoch_end, out_if.epoch_end);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
            || (cfg_if.valid && cfg_if.ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= DOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge; valid stays up between items only when no gap is drawn
    task automatic send_sample(logic [31:0] e);
        int gap;
        gap = draw_gap(tx_quiet);
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.error_sample <= e;
        drive_q.push_back(predict_drive(e));
        do
            @(posedge clk);
        while (!in_if.ready);
        @(negedge clk);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (drive_q.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(stp_pkg::reg_idx_t idx, logic [31:0] value);
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        case (idx)
            stp_pkg::REG_KP:  gain_p = longint'(signed'(value));
            stp_pkg::REG_KI:  gain_i = longint'(signed'(value));
            stp_pkg::REG_KD:  gain_d = longint'(signed'(value));
            stp_pkg::REG_LR:  lrate = 64'(value);
            stp_pkg::REG_LEN: ep_len = value[15:0];
            stp_pkg::REG_THR: rms_thr = 64'(value[30:0]);
            default: ;
        endcase
    endtask

    task automatic test_defaults();
        logic [31:0] pats[12];
        pats = '{32'd0, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'd1, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000};
        foreach (pats[i])
            send_sample(pats[i]);
    endtask

    task automatic test_extremes();
        write_reg(stp_pkg::REG_KP, 32'h7FFF_FFFF);
        write_reg(stp_pkg::REG_KI, 32'h8000_0000);
        write_reg(stp_pkg::REG_KD, 32'h0000_0001);
        write_reg(stp_pkg::REG_LR, 32'hFFFF_FFFF);
        write_reg(stp_pkg::REG_LEN, 32'd1);
        write_reg(stp_pkg::REG_THR, 32'd0);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h0001_0000);
        write_reg(stp_pkg::REG_LR, 32'd0);
        write_reg(stp_pkg::REG_LEN, 32'd2);
        send_sample(32'hFFF0_0000);
        send_sample(32'h0020_0000);
        write_reg(stp_pkg::REG_KP, 32'h8000_0000);
        write_reg(stp_pkg::REG_KD, 32'h7FFF_FFFF);
        send_sample(32'h1234_5678);
        send_sample(32'hEDCB_A988);
    endtask

    // well-formed epochs with random content; tuning kept alive by a low threshold
    task automatic test_tuning();
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(stp_pkg::REG_KP, rand_gain());
            write_reg(stp_pkg::REG_KI, rand_gain());
            write_reg(stp_pkg::REG_KD, rand_gain());
            write_reg(stp_pkg::REG_LR, ph == 0 ? 32'hFFFF_FFFF : $urandom);
            write_reg(stp_pkg::REG_LEN, $urandom_range(1, 12));
            write_reg(stp_pkg::REG_THR, $urandom_range(0, 64));
            tx_quiet = ($urandom_range(0, 2) == 0);
            rx_quiet = ($urandom_range(0, 2) == 0);
            for (int n = 0; n < 55; n++)
            begin
                if (n == 27)
                    drain();
                send_sample(rand_error());
            end
        end
        tx_quiet = 0;
        rx_quiet = 0;
    endtask

    task automatic test_stop_tuning();
        write_reg(stp_pkg::REG_LEN, 32'd3);
        write_reg(stp_pkg::REG_THR, 32'h7FFF_FFFF);
        for (int n = 0; n < 30; n++)
            send_sample(rand_error());
    endtask

    // counter past the length keeps counting; only the write path is reachable here
    task automatic test_length_wrap();
        write_reg(stp_pkg::REG_LEN, 32'd200);
        for (int n = 0; n < 30; n++)
            send_sample(rand_error());
        write_reg(stp_pkg::REG_LEN, 32'd5);
        for (int n = 0; n < 20; n++)
            send_sample(rand_error());
        write_reg(stp_pkg::REG_LEN, 32'd0);
        for (int n = 0; n < 10; n++)
            send_sample(rand_error());
        write_reg(stp_pkg::REG_LEN, 32'hFFFF);
        for (int n = 0; n < 10; n++)
            send_sample(rand_error());
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.error_sample = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = stp_pkg::REG_KP;
        cfg_if.data = '0;
        mismatches = 0;
        stall_left = 0;
        idle_cycles = 0;
        tx_quiet = 0;
        rx_quiet = 0;
        gain_p = 65536;
        gain_i = 0;
        gain_d = 0;
        lrate = 64'(stp_pkg::LR_RST);
        ep_len = stp_pkg::LEN_RST;
        rms_thr = 64'(stp_pkg::THR_RST);
        prev_err = 0;
        err_sum = 0;
        abs_sum = 0;
        sq_sum = 0;
        prev_rms = 0;
        ep_cnt = 0;
        tuning = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_defaults();
        test_extremes();
        test_tuning();
        test_stop_tuning();
        test_length_wrap();

        drain();
        repeat (SETTLE) @(negedge clk);
        if (mismatches == 0 && drive_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
